### hw/rtl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, codes and the ordering compare for the binary heap queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int unsigned CAPACITY_DEF  = 64;
	localparam int unsigned KEY_WIDTH_DEF = 32;
	localparam int unsigned KEY_BITS      = 32;
	localparam int unsigned TOTAL_BITS    = 7;
	localparam int unsigned KEY_W_MAX     = 64;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

	// true when a is served before b
	function automatic logic better(input logic min_first,
			input logic [KEY_W_MAX-1:0] a, input logic [KEY_W_MAX-1:0] b);
		return min_first ? (a < b) : (a > b);
	endfunction

endpackage

### hw/rtl/bhpq_if.sv
// ----------------------------------------------------------------------------
// bhpq channels
// Request, response and configuration channels of the binary heap queue.
// ----------------------------------------------------------------------------
interface bhpq_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [bhpq_pkg::KEY_BITS-1:0] key;

	modport source (output valid, output kind, output key, input ready);
	modport sink   (input valid, input kind, input key, output ready);
endinterface

interface bhpq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      status;
	logic [bhpq_pkg::KEY_BITS-1:0]   popped_key;
	logic [bhpq_pkg::KEY_BITS-1:0]   top_key;
	logic [bhpq_pkg::TOTAL_BITS-1:0] entry_total;
	logic                            is_empty;

	modport source (output valid, output status, output popped_key, output top_key,
		output entry_total, output is_empty, input ready);
	modport sink   (input valid, input status, input popped_key, input top_key,
		input entry_total, input is_empty, output ready);
endinterface

interface bhpq_cfg_if;
	logic valid;
	logic ready;
	logic min_first;

	modport source (output valid, output min_first, input ready);
	modport sink   (input valid, input min_first, output ready);
endinterface

### hw/rtl/bhpq_store.sv
// ----------------------------------------------------------------------------
// bhpq_store
// Key store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhpq_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

### hw/rtl/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Binary heap priority queue with max-first or min-first ordering.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: kind (push key / pop top) and key. rsp returns one
//   item per request: status, popped_key, top_key, entry_total, is_empty.
//   cfg writes min_first (0 largest first, 1 smallest first); the user must do so only while
//   idle, which the block does not enforce.
// Sequencing:
//   One item at a time. The moving key sits in a register and the heap walks
//   one level per step: one key-store read, then compare and write back. Push
//   climbs from the new slot; pop takes the last entry and sinks it from the root.
//   A refused push, or a pop on an empty heap or of the last entry, skips the walk.
// Reset:
//   arst_n empties the heap and selects max-first. No clearing pass is run.
// Stall:
//   A result waits in the output register while the next item is taken and
//   worked on; that item's result is held until rsp drains.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
	parameter int unsigned CAPACITY  = bhpq_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bhpq_req_if.sink    req,
	bhpq_rsp_if.source  rsp,
	bhpq_cfg_if.sink    cfg
);

	import bhpq_pkg::*;

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned PW    = IDX_W + 2;

	state_t state_q, state_d;

	logic [CNT_W-1:0]     count_q;
	logic                 mf_q;
	logic [IDX_W-1:0]     pos_q;
	logic [KEY_WIDTH-1:0] cur_q;
	logic [KEY_WIDTH-1:0] root_q;
	logic [1:0]           status_q;
	logic [KEY_BITS-1:0]  popped_q;

	logic                  rsp_valid_q;
	logic [1:0]            rsp_status_q;
	logic [KEY_BITS-1:0]   rsp_popped_q;
	logic [KEY_BITS-1:0]   rsp_top_q;
	logic [TOTAL_BITS-1:0] rsp_total_q;
	logic                  rsp_empty_q;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;
	logic [IDX_W-1:0]     rd_addr_a;
	logic [IDX_W-1:0]     rd_addr_b;
	logic [KEY_WIDTH-1:0] rd_data_a;
	logic [KEY_WIDTH-1:0] rd_data_b;

	logic                 accept;
	logic                 is_full;
	logic                 no_entry;
	logic                 out_free;
	logic [IDX_W-1:0]     parent_idx;
	logic [IDX_W-1:0]     last_idx;
	logic [PW-1:0]        left_w;
	logic [PW-1:0]        right_w;
	logic [PW-1:0]        cnt_w;
	logic                 has_left;
	logic                 has_right;
	logic                 take_right;
	logic [KEY_WIDTH-1:0] child;
	logic [IDX_W-1:0]     child_idx;
	logic                 child_wins;
	logic                 parent_loses;
	logic [KEY_W_MAX-1:0] key_ext;
	logic [KEY_W_MAX-1:0] root_ext;
	logic [31:0]          cnt_ext;

	bhpq_store #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_WIDTH)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// index arithmetic and compares
	always_comb begin
		accept       = req.valid && req.ready;
		is_full      = count_q == CNT_W'(CAPACITY);
		no_entry     = count_q == '0;
		out_free     = !rsp_valid_q || rsp.ready;
		parent_idx   = (pos_q - IDX_W'(1)) >> 1;
		last_idx     = IDX_W'(count_q - CNT_W'(1));
		left_w       = PW'({pos_q, 1'b1});
		right_w      = left_w + PW'(1);
		cnt_w        = PW'(count_q);
		has_left     = left_w < cnt_w;
		has_right    = right_w < cnt_w;
		take_right   = has_right &&
			better(mf_q, KEY_W_MAX'(rd_data_b), KEY_W_MAX'(rd_data_a));
		child        = take_right ? rd_data_b : rd_data_a;
		child_idx    = take_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
		child_wins   = better(mf_q, KEY_W_MAX'(child), KEY_W_MAX'(cur_q));
		parent_loses = better(mf_q, KEY_W_MAX'(cur_q), KEY_W_MAX'(rd_data_a));
		key_ext      = KEY_W_MAX'(req.key);
		root_ext     = KEY_W_MAX'(root_q);
		cnt_ext      = 32'(count_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.kind == OP_PUSH) begin
						state_d = is_full ? S_DONE : S_UP_RD;
					end else if (no_entry || count_q == CNT_W'(1)) begin
						state_d = S_DONE;
					end else begin
						state_d = S_DN_LAST;
					end
				end
			end
			S_UP_RD:   state_d = (pos_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP:  state_d = parent_loses ? S_UP_RD : S_DONE;
			S_DN_LAST: state_d = S_DN_RD;
			S_DN_RD:   state_d = has_left ? S_DN_CMP : S_DONE;
			S_DN_CMP:  state_d = child_wins ? S_DN_RD : S_DONE;
			S_DONE:    state_d = out_free ? S_IDLE : S_DONE;
			default:   state_d = S_IDLE;
		endcase
	end

	// store accesses and handshake
	always_comb begin
		req.ready = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = cur_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (!no_entry) begin
					rd_addr_a = last_idx;
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_addr_a = parent_idx;
				end
			end
			S_UP_CMP: begin
				wr_en   = 1'b1;
				wr_data = parent_loses ? rd_data_a : cur_q;
			end
			S_DN_RD: begin
				if (has_left) begin
					rd_addr_a = left_w[IDX_W-1:0];
					rd_addr_b = has_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
				end else begin
					wr_en = 1'b1;
				end
			end
			S_DN_CMP: begin
				wr_en   = 1'b1;
				wr_data = child_wins ? child : cur_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			mf_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				mf_q <= cfg.min_first;
			end
			if (state_q == S_IDLE && accept) begin
				if (req.kind == OP_PUSH && !is_full) begin
					count_q <= count_q + CNT_W'(1);
				end else if (req.kind == OP_POP && !no_entry) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			if (req.kind == OP_PUSH) begin
				status_q <= is_full ? ST_FULL : ST_OK;
				popped_q <= '0;
				cur_q    <= key_ext[KEY_WIDTH-1:0];
				pos_q    <= IDX_W'(count_q);
			end else begin
				status_q <= no_entry ? ST_EMPTY : ST_OK;
				popped_q <= no_entry ? '0 : root_ext[KEY_BITS-1:0];
				pos_q    <= '0;
			end
		end
		if (state_q == S_DN_LAST) begin
			cur_q <= rd_data_a;
		end
		if (state_q == S_UP_CMP && parent_loses) begin
			pos_q <= parent_idx;
		end
		if (state_q == S_DN_CMP && child_wins) begin
			pos_q <= child_idx;
		end
		if (wr_en && wr_addr == '0) begin
			root_q <= wr_data;
		end
		if (state_q == S_DONE && out_free) begin
			rsp_status_q <= status_q;
			rsp_popped_q <= popped_q;
			rsp_top_q    <= no_entry ? '0 : root_ext[KEY_BITS-1:0];
			rsp_total_q  <= cnt_ext[TOTAL_BITS-1:0];
			rsp_empty_q  <= no_entry;
		end
	end

	assign cfg.ready       = 1'b1;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.popped_key  = rsp_popped_q;
	assign rsp.top_key     = rsp_top_q;
	assign rsp.entry_total = rsp_total_q;
	assign rsp.is_empty    = rsp_empty_q;

endmodule
